FILE: rtl/dual_sensor_temp_fusion_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual sensor temperature fusion core
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef DUAL_SENSOR_TEMP_FUSION_CORE_MACROS_SVH
`define DUAL_SENSOR_TEMP_FUSION_CORE_MACROS_SVH

// same-cycle implication
`define DSTF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dual_sensor_temp_fusion_core: same-cycle check failed");

// next-cycle implication
`define DSTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dual_sensor_temp_fusion_core: next-cycle check failed");

`endif

FILE: rtl/dstf_pkg.sv
// ----------------------------------------------------------------------------
// dstf_pkg
// Shared types, constants and arithmetic helpers of the temperature fusion core.
// ----------------------------------------------------------------------------
package dstf_pkg;

   // widths
   localparam int TEMP_W        = 19;
   localparam int DEG_W         = 9;
   localparam int CUR_W         = 16;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 3;
   localparam int ENTRY_W       = 32;
   localparam int THR_W         = 16;
   localparam int OFS_W         = 16;

   // compensation table
   localparam int COMP_ENTRIES  = 6;
   localparam int NUM_COMP_REGS = 3;

   // temperature constants, millidegrees
   localparam int SLEW_LIMIT    = 1000;
   localparam int SPREAD_LIMIT  = 10000;
   localparam int FALLBACK_TEMP = -40000;
   localparam int TEMP_FLOOR    = -50000;
   localparam int TEMP_CEIL     = 150000;
   localparam int RESET_LOW     = 15000;
   localparam int RESET_HIGH    = 40000;

   // reciprocal multipliers for truncating divides
   localparam logic [19:0] DIV3_RECIP    = 20'd699051;  // ceil(2^21 / 3)
   localparam logic [19:0] DIV1000_RECIP = 20'd536871;  // ceil(2^29 / 1000)

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_COMP_ENABLE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_LOW  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW_HIGH = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMP_01     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMP_23     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMP_45     = 3'd5;

   // request tdata layout
   localparam int S0_A_LSB   = 0;
   localparam int S0_B_LSB   = 19;
   localparam int S0_C_LSB   = 38;
   localparam int S0_FAIL    = 57;
   localparam int S1_A_LSB   = 58;
   localparam int S1_B_LSB   = 77;
   localparam int S1_C_LSB   = 96;
   localparam int S1_FAIL    = 115;
   localparam int CUR_LSB    = 116;
   localparam int RESYNC_BIT = 132;
   localparam int REQ_W      = 136;

   // response tdata layout
   localparam int RSP_USED_W = 3 * TEMP_W + 4 * DEG_W + 2;
   localparam int RSP_W      = 96;
   localparam int RSP_PAD_W  = RSP_W - RSP_USED_W;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic signed [DEG_W-1:0]  deg_type;
   typedef logic [NUM_COMP_REGS-1:0][CSR_DATA_W-1:0] comp_regs_type;

   typedef struct packed {
      temp_type a;
      temp_type b;
      temp_type c;
      logic     fail;
   } sensor_in_type;

   typedef struct packed {
      temp_type temp;
      logic     invalid;
   } lane_out_type;

   typedef struct packed {
      temp_type t0;
      temp_type t1;
      temp_type mixed;
      logic     inv0;
      logic     inv1;
   } mix_out_type;

   // sum / 3, truncated toward zero
   function automatic temp_type div3_trunc(input logic signed [20:0] s);
      logic [19:0] mag;
      logic [39:0] prod;
      logic [18:0] q;
      mag  = s[20] ? 20'(-s) : 20'(s);
      prod = mag * DIV3_RECIP;
      q    = prod[39:21];
      return s[20] ? 19'(-q) : q;
   endfunction

   // value / 1000, truncated toward zero, low bits kept
   function automatic deg_type div1000_trunc(input temp_type v);
      logic [18:0] mag;
      logic [38:0] prod;
      logic [9:0]  q;
      logic [9:0]  r;
      mag  = v[18] ? 19'(-v) : 19'(v);
      prod = mag * DIV1000_RECIP;
      q    = prod[38:29];
      r    = v[18] ? 10'(-q) : q;
      return r[8:0];
   endfunction

   function automatic temp_type sat_temp(input logic signed [20:0] v);
      if (v < 21'(TEMP_FLOOR)) begin
         return 19'(TEMP_FLOOR);
      end
      if (v > 21'(TEMP_CEIL)) begin
         return 19'(TEMP_CEIL);
      end
      return v[18:0];
   endfunction

   // limit the step from prev to cur
   function automatic temp_type slew_step(input temp_type cur, input temp_type prev);
      logic signed [19:0] d;
      d = 20'(cur) - 20'(prev);
      if (d > 20'(SLEW_LIMIT)) begin
         return prev + 19'(SLEW_LIMIT);
      end
      if (d < -20'(SLEW_LIMIT)) begin
         return prev - 19'(SLEW_LIMIT);
      end
      return cur;
   endfunction

endpackage

FILE: rtl/dual_sensor_temp_fusion_core.sv
// ----------------------------------------------------------------------------
// dual_sensor_temp_fusion_core
// Battery temperature fusion for a pack with two temperature sensors.
// ----------------------------------------------------------------------------
// Each request transaction carries three millidegree samples and a read-fail
// flag per sensor, the charge current and a resync flag. Two identical lanes
// reduce each sensor to one compensated, clamped temperature (fallback of
// -40000 on a failed read or a spread above 10000), a merge stage mixes them
// against the window bounds, and a slew stage limits all three values to
// +-1000 per transaction (the first transaction after reset, or one with
// resync set, loads directly). One response transaction per request.
// Rate: one transaction per clock while the pipeline advances. rsp_tvalid rises
// once a request has passed five registers in line (two lane registers, the
// merge register, the slew state register and the output register), the
// first of them loaded at the accept edge itself. The whole pipeline advances
// together whenever the output register is empty or being taken, so
// req_tready follows rsp_tready while the output is full.
// Configuration is written through csr_* between traffic; writes to indexes
// beyond the register list are dropped.
// ----------------------------------------------------------------------------
`include "dual_sensor_temp_fusion_core_macros.svh"

module dual_sensor_temp_fusion_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_tvalid,
   output logic                             req_tready,
   // lsb up: s0_sample_a, s0_sample_b, s0_sample_c, s0_read_fail,
   // s1_sample_a, s1_sample_b, s1_sample_c, s1_read_fail,
   // charge_current, resync, zero pad
   input  logic [dstf_pkg::REQ_W-1:0]       req_tdata,

   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // lsb up: temp0_smooth, temp1_smooth, mixed_smooth, temp0_deg,
   // temp1_deg, mixed_deg, now_mixed_deg, s0_invalid, s1_invalid, zero pad
   output logic [dstf_pkg::RSP_W-1:0]       rsp_tdata,

   input  logic                             csr_wen,
   input  logic [dstf_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [dstf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // ---------------- configuration registers ----------------
   logic                    comp_enable_ff;
   dstf_pkg::temp_type      window_low_ff;
   dstf_pkg::temp_type      window_high_ff;
   dstf_pkg::comp_regs_type comp_regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_enable_ff <= 1'b0;
         window_low_ff  <= 19'(dstf_pkg::RESET_LOW);
         window_high_ff <= 19'(dstf_pkg::RESET_HIGH);
         comp_regs_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            dstf_pkg::CSR_COMP_ENABLE: comp_enable_ff  <= csr_wdata[0];
            dstf_pkg::CSR_WINDOW_LOW:  window_low_ff   <= csr_wdata[dstf_pkg::TEMP_W-1:0];
            dstf_pkg::CSR_WINDOW_HIGH: window_high_ff  <= csr_wdata[dstf_pkg::TEMP_W-1:0];
            dstf_pkg::CSR_COMP_01:     comp_regs_ff[0] <= csr_wdata;
            dstf_pkg::CSR_COMP_23:     comp_regs_ff[1] <= csr_wdata;
            dstf_pkg::CSR_COMP_45:     comp_regs_ff[2] <= csr_wdata;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // stage_valid_ff: [0] lane stage 1, [1] lane stage 2, [2] merge, [3] slew state
   logic       adv;
   logic [3:0] stage_valid_ff;
   logic [2:0] resync_ff;
   logic       rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   // ---------------- request unpack ----------------
   dstf_pkg::sensor_in_type s0_in, s1_in;
   logic signed [15:0]      cur_in;

   always_comb begin
      s0_in.a    = req_tdata[dstf_pkg::S0_A_LSB +: dstf_pkg::TEMP_W];
      s0_in.b    = req_tdata[dstf_pkg::S0_B_LSB +: dstf_pkg::TEMP_W];
      s0_in.c    = req_tdata[dstf_pkg::S0_C_LSB +: dstf_pkg::TEMP_W];
      s0_in.fail = req_tdata[dstf_pkg::S0_FAIL];
      s1_in.a    = req_tdata[dstf_pkg::S1_A_LSB +: dstf_pkg::TEMP_W];
      s1_in.b    = req_tdata[dstf_pkg::S1_B_LSB +: dstf_pkg::TEMP_W];
      s1_in.c    = req_tdata[dstf_pkg::S1_C_LSB +: dstf_pkg::TEMP_W];
      s1_in.fail = req_tdata[dstf_pkg::S1_FAIL];
      cur_in     = req_tdata[dstf_pkg::CUR_LSB +: dstf_pkg::CUR_W];
   end

   // ---------------- sensor lanes ----------------
   dstf_pkg::lane_out_type lane0, lane1;

   dstf_lane u_lane0 (
      .clock          (clock),
      .adv            (adv),
      .comp_enable    (comp_enable_ff),
      .comp_regs      (comp_regs_ff),
      .sensor         (s0_in),
      .charge_current (cur_in),
      .lane_out       (lane0)
   );

   dstf_lane u_lane1 (
      .clock          (clock),
      .adv            (adv),
      .comp_enable    (comp_enable_ff),
      .comp_regs      (comp_regs_ff),
      .sensor         (s1_in),
      .charge_current (cur_in),
      .lane_out       (lane1)
   );

   // ---------------- merge ----------------
   dstf_pkg::mix_out_type mix_out;

   dstf_mix u_mix (
      .clock       (clock),
      .adv         (adv),
      .window_low  (window_low_ff),
      .window_high (window_high_ff),
      .lane0       (lane0),
      .lane1       (lane1),
      .mix_out     (mix_out)
   );

   // ---------------- slew state ----------------
   logic               primed_ff;
   dstf_pkg::temp_type last_temp0_ff, last_temp0_in;
   dstf_pkg::temp_type last_temp1_ff, last_temp1_in;
   dstf_pkg::temp_type last_mixed_ff, last_mixed_in;
   dstf_pkg::temp_type now_mixed_ff;
   logic               inv0_ff, inv1_ff;
   logic               load_direct;
   logic               slew_upd;

   // first transaction after reset or a resync loads without limiting
   assign load_direct = !primed_ff || resync_ff[2];
   assign slew_upd    = adv && stage_valid_ff[2] && !load_direct;

   always_comb begin
      if (load_direct) begin
         last_temp0_in = mix_out.t0;
         last_temp1_in = mix_out.t1;
         last_mixed_in = mix_out.mixed;
      end else begin
         last_temp0_in = dstf_pkg::slew_step(mix_out.t0, last_temp0_ff);
         last_temp1_in = dstf_pkg::slew_step(mix_out.t1, last_temp1_ff);
         last_mixed_in = dstf_pkg::slew_step(mix_out.mixed, last_mixed_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         resync_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         primed_ff      <= 1'b0;
         last_temp0_ff  <= '0;
         last_temp1_ff  <= '0;
         last_mixed_ff  <= '0;
      end else if (adv) begin
         stage_valid_ff <= {stage_valid_ff[2:0], req_tvalid};
         resync_ff      <= {resync_ff[1:0], req_tdata[dstf_pkg::RESYNC_BIT]};
         rsp_valid_ff   <= stage_valid_ff[3];
         if (stage_valid_ff[2]) begin
            primed_ff     <= 1'b1;
            last_temp0_ff <= last_temp0_in;
            last_temp1_ff <= last_temp1_in;
            last_mixed_ff <= last_mixed_in;
         end
      end
   end

   // payload riding beside the slew state
   always_ff @(posedge clock) begin
      if (adv) begin
         now_mixed_ff <= mix_out.mixed;
         inv0_ff      <= mix_out.inv0;
         inv1_ff      <= mix_out.inv1;
      end
   end

   // ---------------- output register ----------------
   logic [dstf_pkg::RSP_W-1:0] rsp_data_in, rsp_data_ff;

   always_comb begin
      rsp_data_in = {{dstf_pkg::RSP_PAD_W{1'b0}},
                     inv1_ff,
                     inv0_ff,
                     dstf_pkg::div1000_trunc(now_mixed_ff),
                     dstf_pkg::div1000_trunc(last_mixed_ff),
                     dstf_pkg::div1000_trunc(last_temp1_ff),
                     dstf_pkg::div1000_trunc(last_temp0_ff),
                     last_mixed_ff,
                     last_temp1_ff,
                     last_temp0_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

   // ---------------- assertions ----------------
   // a response can only exist once the slew state has been loaded
   `DSTF_ASSERT_NOW(a_rsp_needs_primed, clock, reset, rsp_valid_ff, primed_ff)
   // limited updates never move a stored value by more than the slew step
   `DSTF_ASSERT_NEXT(a_slew_temp0, clock, reset, slew_upd,
      ((last_temp0_ff - $past(last_temp0_ff)) <= dstf_pkg::SLEW_LIMIT) &&
      (($past(last_temp0_ff) - last_temp0_ff) <= dstf_pkg::SLEW_LIMIT))
   `DSTF_ASSERT_NEXT(a_slew_mixed, clock, reset, slew_upd,
      ((last_mixed_ff - $past(last_mixed_ff)) <= dstf_pkg::SLEW_LIMIT) &&
      (($past(last_mixed_ff) - last_mixed_ff) <= dstf_pkg::SLEW_LIMIT))

endmodule

FILE: rtl/dstf_lane.sv
// ----------------------------------------------------------------------------
// dstf_lane
// One sensor lane: spread check, mean, current compensation, saturation.
// ----------------------------------------------------------------------------
module dstf_lane (
   input  logic                    clock,
   input  logic                    adv,
   input  logic                    comp_enable,
   input  dstf_pkg::comp_regs_type comp_regs,
   input  dstf_pkg::sensor_in_type sensor,
   input  logic signed [15:0]      charge_current,
   output dstf_pkg::lane_out_type  lane_out
);

   dstf_pkg::temp_type     mx;
   dstf_pkg::temp_type     mn;
   logic [19:0]            spread;
   logic signed [16:0]     cur_ext;
   logic [16:0]            mag;
   logic [31:0]            word;
   logic signed [20:0]     sum_in, sum_ff;
   logic                   bad_in, bad_ff;
   logic signed [16:0]     off_in, off_ff;
   logic signed [20:0]     base;
   logic signed [20:0]     comp;
   dstf_pkg::lane_out_type out_in, out_ff;

   // first stage: spread, sum, table lookup
   always_comb begin
      mx = sensor.a;
      if (sensor.b > mx) mx = sensor.b;
      if (sensor.c > mx) mx = sensor.c;
      mn = sensor.a;
      if (sensor.b < mn) mn = sensor.b;
      if (sensor.c < mn) mn = sensor.c;
      spread = 20'({mx[18], mx} - {mn[18], mn});
      bad_in = sensor.fail || (spread > 20'(dstf_pkg::SPREAD_LIMIT));
      sum_in = 21'(sensor.a) + 21'(sensor.b) + 21'(sensor.c);

      cur_ext = 17'(charge_current);
      mag     = cur_ext[16] ? 17'(-cur_ext) : 17'(cur_ext);

      // descending scan so the lowest matching entry wins
      word   = '0;
      off_in = '0;
      if (comp_enable) begin
         for (int k = dstf_pkg::COMP_ENTRIES - 1; k >= 0; k--) begin
            word = comp_regs[k / 2][(k % 2) * dstf_pkg::ENTRY_W +: dstf_pkg::ENTRY_W];
            if (mag >= {1'b0, word[dstf_pkg::THR_W-1:0]}) begin
               off_in = 17'($signed(word[dstf_pkg::THR_W +: dstf_pkg::OFS_W]));
            end
         end
      end
   end

   // second stage: mean or fallback, offset, clamp
   always_comb begin
      base = bad_ff ? 21'(dstf_pkg::FALLBACK_TEMP) : 21'(dstf_pkg::div3_trunc(sum_ff));
      comp = base - 21'(off_ff);
      out_in.temp    = dstf_pkg::sat_temp(comp);
      out_in.invalid = bad_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         bad_ff <= bad_in;
         off_ff <= off_in;
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

FILE: rtl/dstf_mix.sv
// ----------------------------------------------------------------------------
// dstf_mix
// Merge stage: combines the two lane temperatures by window rules.
// ----------------------------------------------------------------------------
module dstf_mix (
   input  logic                   clock,
   input  logic                   adv,
   input  dstf_pkg::temp_type     window_low,
   input  dstf_pkg::temp_type     window_high,
   input  dstf_pkg::lane_out_type lane0,
   input  dstf_pkg::lane_out_type lane1,
   output dstf_pkg::mix_out_type  mix_out
);

   dstf_pkg::temp_type    a, b, lo, hi;
   logic                  a_lt_lo, a_gt_lo, b_lt_lo, b_gt_lo;
   logic                  a_lt_hi, a_gt_hi, b_lt_hi, b_gt_hi;
   logic                  p1_neg, p2_neg;
   logic signed [19:0]    lo_m_a, b_m_hi, a_m_hi, lo_m_b;
   logic signed [19:0]    sum, sum_adj;
   dstf_pkg::temp_type    mixed;
   dstf_pkg::mix_out_type out_in, out_ff;

   always_comb begin
      a  = lane0.temp;
      b  = lane1.temp;
      lo = window_low;
      hi = window_high;

      a_lt_lo = a < lo;
      a_gt_lo = a > lo;
      b_lt_lo = b < lo;
      b_gt_lo = b > lo;
      a_lt_hi = a < hi;
      a_gt_hi = a > hi;
      b_lt_hi = b < hi;
      b_gt_hi = b > hi;

      // product sign tests without the multiply
      p1_neg = (a_lt_lo && b_gt_lo) || (a_gt_lo && b_lt_lo);
      p2_neg = (a_lt_hi && b_gt_hi) || (a_gt_hi && b_lt_hi);

      lo_m_a = 20'(lo) - 20'(a);
      b_m_hi = 20'(b) - 20'(hi);
      a_m_hi = 20'(a) - 20'(hi);
      lo_m_b = 20'(lo) - 20'(b);

      // average, truncated toward zero
      sum     = 20'(a) + 20'(b);
      sum_adj = sum + $signed({19'b0, sum[19]});

      priority if (a_lt_lo && b_gt_hi) begin
         mixed = (lo_m_a > b_m_hi) ? a : b;
      end else if (a_gt_hi && b_lt_lo) begin
         mixed = (a_m_hi > lo_m_b) ? a : b;
      end else if ((a_lt_lo && b_lt_lo) || p1_neg) begin
         mixed = (a < b) ? a : b;
      end else if ((a_gt_hi && b_gt_hi) || p2_neg) begin
         mixed = (a > b) ? a : b;
      end else begin
         mixed = 19'(sum_adj >>> 1);
      end

      out_in.t0    = a;
      out_in.t1    = b;
      out_in.mixed = mixed;
      out_in.inv0  = lane0.invalid;
      out_in.inv1  = lane1.invalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign mix_out = out_ff;

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: dual sensor temperature fusion core
// Drives update transactions in bursts against a stalling receiver and checks
// every response against a cycle-free predictor kept in a scoreboard class.
// The run has a directed opening and then random phases, each with its own
// register setting. Extremes and reversed windows are among the settings.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dstf_pkg::*;

   localparam int MILLI_PER_DEG = 1000;
   localparam int CYCLE_LIMIT   = 200000;   // far above the slowest legal run
   localparam int LONG_HOLD     = 400;      // receiver hold-off, cycles
   localparam int FIELD_COUNT   = 9;

   // spare register indexes, writes there must be dropped
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_7 = 3'd7;

   // one update transaction, fields as the request carries them
   typedef struct packed {
      sensor_in_type        s0;
      sensor_in_type        s1;
      logic signed [15:0]   current;
      logic                 resync;
   } fusion_update;

   // response layout, first member in the highest bits, so the cast of
   // rsp_tdata[RSP_USED_W-1:0] lines up field by field
   typedef struct packed {
      logic     inv1;
      logic     inv0;
      deg_type  now_deg;
      deg_type  mix_deg;
      deg_type  t1_deg;
      deg_type  t0_deg;
      temp_type mix;
      temp_type t1;
      temp_type t0;
   } fusion_result;

   // -------------------------------------------------------------------------
   // Scoreboard: register mirror, fusion state and the queue of expected
   // responses. note_update() predicts one response per accepted update.
   // -------------------------------------------------------------------------
   class fusion_scoreboard;
      bit             comp_on;
      temp_type       win_lo;
      temp_type       win_hi;
      logic [63:0]    comp_word [NUM_COMP_REGS];
      bit             primed;
      temp_type       last_t0;
      temp_type       last_t1;
      temp_type       last_mix;
      fusion_result   expected_q [$];
      int             mismatches;
      int             rsp_count;

      function new();
         comp_on    = 1'b0;
         win_lo     = temp_type'(RESET_LOW);
         win_hi     = temp_type'(RESET_HIGH);
         foreach (comp_word[i]) comp_word[i] = '0;
         primed     = 1'b0;
         last_t0    = '0;
         last_t1    = '0;
         last_mix   = '0;
         mismatches = 0;
         rsp_count  = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [63:0] value);
         case (idx)
            CSR_COMP_ENABLE: comp_on = value[0];
            CSR_WINDOW_LOW:  win_lo  = value[TEMP_W-1:0];
            CSR_WINDOW_HIGH: win_hi  = value[TEMP_W-1:0];
            CSR_COMP_01:     comp_word[0] = value;
            CSR_COMP_23:     comp_word[1] = value;
            CSR_COMP_45:     comp_word[2] = value;
            default: ;
         endcase
      endfunction

      // one sensor: fallback or truncated mean, table offset, clamp
      function temp_type lane_temp(sensor_in_type s, longint mag, output bit invalid);
         longint      a, b, c, hi, lo, t, thr;
         logic [31:0] entry;
         a = s.a;
         b = s.b;
         c = s.c;
         hi = a;
         lo = a;
         if (b > hi) hi = b;
         if (c > hi) hi = c;
         if (b < lo) lo = b;
         if (c < lo) lo = c;
         if (s.fail || hi - lo > SPREAD_LIMIT) begin
            invalid = 1'b1;
            t = FALLBACK_TEMP;
         end else begin
            invalid = 1'b0;
            t = (a + b + c) / 3;
         end
         if (comp_on) begin
            // first entry whose threshold is reached wins
            for (int k = 0; k < COMP_ENTRIES; k++) begin
               entry = comp_word[k / 2][(k % 2) * 32 +: 32];
               thr = entry[15:0];
               if (mag >= thr) begin
                  t = t - longint'(signed'(entry[31:16]));
                  break;
               end
            end
         end
         if (t < TEMP_FLOOR) t = TEMP_FLOOR;
         else if (t > TEMP_CEIL) t = TEMP_CEIL;
         return temp_type'(t);
      endfunction

      // window rules, checked in order of precedence
      function temp_type mix_temps(temp_type t0, temp_type t1);
         longint a, b, lo, hi, p_lo, p_hi;
         a = t0;
         b = t1;
         lo = win_lo;
         hi = win_hi;
         p_lo = (a - lo) * (b - lo);
         p_hi = (a - hi) * (b - hi);
         if (a < lo && b > hi) return (lo - a > b - hi) ? t0 : t1;
         if (a > hi && b < lo) return (a - hi > lo - b) ? t0 : t1;
         if ((a < lo && b < lo) || p_lo < 0) return (a < b) ? t0 : t1;
         if ((a > hi && b > hi) || p_hi < 0) return (a > b) ? t0 : t1;
         return temp_type'((a + b) / 2);
      endfunction

      function temp_type limit_step(temp_type target, temp_type prev);
         longint d;
         d = longint'(target) - longint'(prev);
         if (d > SLEW_LIMIT) return temp_type'(longint'(prev) + SLEW_LIMIT);
         if (d < -SLEW_LIMIT) return temp_type'(longint'(prev) - SLEW_LIMIT);
         return target;
      endfunction

      function void note_update(fusion_update u);
         longint       mag;
         bit           inv0, inv1;
         temp_type     t0, t1, m;
         fusion_result r;
         mag = longint'(signed'(u.current));
         if (mag < 0) mag = -mag;
         t0 = lane_temp(u.s0, mag, inv0);
         t1 = lane_temp(u.s1, mag, inv1);
         m  = mix_temps(t0, t1);
         if (!primed || u.resync) begin
            last_t0  = t0;
            last_t1  = t1;
            last_mix = m;
            primed   = 1'b1;
         end else begin
            last_t0  = limit_step(t0, last_t0);
            last_t1  = limit_step(t1, last_t1);
            last_mix = limit_step(m, last_mix);
         end
         r.t0      = last_t0;
         r.t1      = last_t1;
         r.mix     = last_mix;
         r.t0_deg  = deg_type'(longint'(last_t0) / MILLI_PER_DEG);
         r.t1_deg  = deg_type'(longint'(last_t1) / MILLI_PER_DEG);
         r.mix_deg = deg_type'(longint'(last_mix) / MILLI_PER_DEG);
         r.now_deg = deg_type'(longint'(m) / MILLI_PER_DEG);
         r.inv0    = inv0;
         r.inv1    = inv1;
         expected_q.push_back(r);
      endfunction

      function void field_info(int f, output int lsb, output int w, output string name);
         case (f)
            0: begin lsb = 0;  w = TEMP_W; name = "temp0_smooth";  end
            1: begin lsb = 19; w = TEMP_W; name = "temp1_smooth";  end
            2: begin lsb = 38; w = TEMP_W; name = "mixed_smooth";  end
            3: begin lsb = 57; w = DEG_W;  name = "temp0_deg";     end
            4: begin lsb = 66; w = DEG_W;  name = "temp1_deg";     end
            5: begin lsb = 75; w = DEG_W;  name = "mixed_deg";     end
            6: begin lsb = 84; w = DEG_W;  name = "now_mixed_deg"; end
            7: begin lsb = 93; w = 1;      name = "s0_invalid";    end
            default: begin lsb = 94; w = 1; name = "s1_invalid";   end
         endcase
      endfunction

      function void check_response(logic [RSP_W-1:0] d);
         fusion_result          want;
         logic [RSP_USED_W-1:0] wb, gb, wf, gf;
         int                    lsb, w;
         string                 name;
         rsp_count++;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("mismatch: response %0d with nothing outstanding, data %h",
                        rsp_count, d);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         wb = want;
         gb = d[RSP_USED_W-1:0];
         for (int f = 0; f < FIELD_COUNT; f++) begin
            field_info(f, lsb, w, name);
            wf = (wb >> lsb) & ~({RSP_USED_W{1'b1}} << w);
            gf = (gb >> lsb) & ~({RSP_USED_W{1'b1}} << w);
            if (wf !== gf) begin
               if (mismatches < 10)
                  $display("mismatch: response %0d field %s expected %h got %h",
                           rsp_count, name, wf, gf);
               mismatches++;
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT and its signals
   // -------------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fusion_scoreboard sb;
   bit               hold_request = 1'b0;  // asks the receiver for a long hold-off
   int               drift_temp = 25000;   // slowly wandering pack temperature
   int               cycle_count;

   dual_sensor_temp_fusion_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // response monitor, samples pre-edge values
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   // receiver: random stall modes, plus a long hold-off on request
   initial begin : rsp_stall_gen
      int mode;
      int mode_left;
      int hold_left;
      rsp_tready <= 1'b0;
      mode = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(8, 60);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;                           // no stalls
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
               default: rsp_tready <= ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Drive helpers
   // -------------------------------------------------------------------------
   task automatic send_update(input fusion_update u);
      logic [REQ_W-1:0] bits;
      bits = '0;
      bits[S0_A_LSB +: TEMP_W] = u.s0.a;
      bits[S0_B_LSB +: TEMP_W] = u.s0.b;
      bits[S0_C_LSB +: TEMP_W] = u.s0.c;
      bits[S0_FAIL]            = u.s0.fail;
      bits[S1_A_LSB +: TEMP_W] = u.s1.a;
      bits[S1_B_LSB +: TEMP_W] = u.s1.b;
      bits[S1_C_LSB +: TEMP_W] = u.s1.c;
      bits[S1_FAIL]            = u.s1.fail;
      bits[CUR_LSB +: CUR_W]   = u.current;
      bits[RESYNC_BIT]         = u.resync;
      req_tdata  <= bits;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_update(u);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [63:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // sender pause: nothing is written until the pipeline has drained
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // window bound in the low bits, random junk above
   function automatic logic [63:0] window_word(int w);
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      v[TEMP_W-1:0] = temp_type'(w);
      return v;
   endfunction

   function automatic logic [63:0] comp_pair(int thr0, int ofs0, int thr1, int ofs1);
      return {16'(ofs1), 16'(thr1), 16'(ofs0), 16'(thr0)};
   endfunction

   function automatic fusion_update update_of(int a0, int b0, int c0, bit f0,
                                              int a1, int b1, int c1, bit f1,
                                              int cur, bit rs);
      fusion_update u;
      u.s0.a = temp_type'(a0);
      u.s0.b = temp_type'(b0);
      u.s0.c = temp_type'(c0);
      u.s0.fail = f0;
      u.s1.a = temp_type'(a1);
      u.s1.b = temp_type'(b1);
      u.s1.c = temp_type'(c1);
      u.s1.fail = f1;
      u.current = 16'(cur);
      u.resync = rs;
      return u;
   endfunction

   // samples around a center: mostly tight, some near the spread limit,
   // some raw 19-bit noise, some anywhere in range
   function automatic sensor_in_type make_sensor(int center);
      sensor_in_type s;
      int            pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         s.a = temp_type'(center + int'($urandom_range(0, 6000)) - 3000);
         s.b = temp_type'(center + int'($urandom_range(0, 6000)) - 3000);
         s.c = temp_type'(center + int'($urandom_range(0, 6000)) - 3000);
      end else if (pick < 85) begin
         s.a = temp_type'(center - 5000);
         s.b = temp_type'(center + 5000 + int'($urandom_range(0, 1)));
         s.c = temp_type'(center + int'($urandom_range(0, 10000)) - 5000);
      end else if (pick < 93) begin
         s.a = temp_type'($urandom());
         s.b = temp_type'($urandom());
         s.c = temp_type'($urandom());
      end else begin
         s.a = temp_type'(int'($urandom_range(0, 200000)) - 50000);
         s.b = temp_type'(int'($urandom_range(0, 200000)) - 50000);
         s.c = temp_type'(int'($urandom_range(0, 200000)) - 50000);
      end
      s.fail = ($urandom_range(0, 19) == 0);
      return s;
   endfunction

   // random updates in bursts with random gaps
   task automatic run_random(input int count);
      fusion_update u;
      int           burst;
      int           gap;
      while (count > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && count > 0) begin
            if ($urandom_range(0, 19) == 0)
               drift_temp = int'($urandom_range(0, 210000)) - 60000;
            else
               drift_temp += int'($urandom_range(0, 3000)) - 1500;
            u.s0 = make_sensor(drift_temp);
            u.s1 = make_sensor(drift_temp + int'($urandom_range(0, 30000)) - 15000);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: u.current = 16'(int'($urandom_range(0, 8000)) - 4000);
               6, 7, 8:          u.current = 16'($urandom());
               default:          u.current = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
            endcase
            u.resync = ($urandom_range(0, 24) == 0);
            send_update(u);
            burst--;
            count--;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0 && count > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_addr   <= CSR_COMP_ENABLE;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset register values: no compensation, window 15000..40000
      // first update after reset loads directly
      send_update(update_of(20000, 20000, 20000, 0, 30000, 30000, 30000, 0, 0, 0));
      // slew limited step
      send_update(update_of(25000, 25000, 25000, 0, 30000, 30000, 30000, 0, 0, 0));
      // read failure, fallback temperature
      send_update(update_of(25000, 25000, 25000, 1, 30000, 30000, 30000, 0, 0, 0));
      // spread right at the limit (valid) and one past it (invalid)
      send_update(update_of(20000, 30000, 25000, 0, 20000, 30001, 25000, 0, 0, 0));
      // out of range samples saturate, with resync
      send_update(update_of(262143, 262143, 262143, 0, -262144, -262144, -262144, 0,
                            0, 1));
      // mean of negatives truncates toward zero
      send_update(update_of(-1, -1, -2, 0, -2, -2, -1, 0, 0, 1));
      // window rules: straddling both bounds each way, both out each side,
      // crossing one bound, both inside
      send_update(update_of(10000, 10000, 10000, 0, 50000, 50000, 50000, 0, 0, 1));
      send_update(update_of(60000, 60000, 60000, 0, 0, 0, 0, 0, 0, 1));
      send_update(update_of(5000, 5000, 5000, 0, 10000, 10000, 10000, 0, 0, 1));
      send_update(update_of(50000, 50000, 50000, 0, 45000, 45000, 45000, 0, 0, 1));
      send_update(update_of(10000, 10000, 10000, 0, 20000, 20000, 20000, 0, 0, 1));
      send_update(update_of(30000, 30000, 30000, 0, 45000, 45000, 45000, 0, 0, 1));
      send_update(update_of(20000, 20000, 20000, 0, 25001, 25001, 25001, 0, 0, 1));
      req_tvalid <= 1'b0;

      // compensation on, reversed window, hand-picked table;
      // spare indexes get junk that must not land anywhere
      wait_idle();
      write_reg(CSR_COMP_ENABLE, 64'd1);
      write_reg(CSR_WINDOW_LOW, window_word(40000));
      write_reg(CSR_WINDOW_HIGH, window_word(15000));
      write_reg(CSR_COMP_01, comp_pair(20000, 3000, 5000, -2000));
      write_reg(CSR_COMP_23, comp_pair(100, 32767, 50, -32768));
      write_reg(CSR_COMP_45, comp_pair(10, 1, 10, 7));
      write_reg(CSR_SPARE_6, {64{1'b1}});
      write_reg(CSR_SPARE_7, {64{1'b1}});
      csr_wen <= 1'b0;

      // no entry reached
      send_update(update_of(20000, 20000, 20000, 1, 30000, 30000, 30000, 0, 0, 1));
      send_update(update_of(20000, 20000, 20000, 0, 30000, 30000, 30000, 0, 5, 0));
      // largest magnitude, fallback also compensated
      send_update(update_of(20000, 20000, 20000, 1, 0, 0, 0, 1, -32768, 0));
      send_update(update_of(20000, 20000, 20000, 0, 30000, 30000, 30000, 0, 32767, 1));
      // large positive offset and large negative offset with clamp
      send_update(update_of(20000, 20000, 20000, 0, 10000, 10000, 10000, 0, -100, 1));
      send_update(update_of(140000, 140000, 140000, 0, 30000, 30000, 30000, 0, 60, 1));
      // reversed window with values between the bounds, then outside them
      send_update(update_of(20000, 20000, 20000, 0, 30000, 30000, 30000, 0, 1, 1));
      send_update(update_of(45000, 45000, 45000, 0, 10000, 10000, 10000, 0, 7, 0));
      req_tvalid <= 1'b0;

      // random phases, one register setting each
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: begin  // widest window, no compensation
               write_reg(CSR_COMP_ENABLE, {$urandom(), $urandom() & 32'hffff_fffe});
               write_reg(CSR_WINDOW_LOW, window_word(TEMP_FLOOR));
               write_reg(CSR_WINDOW_HIGH, window_word(TEMP_CEIL));
               write_reg(CSR_COMP_01, {$urandom(), $urandom()});
               write_reg(CSR_COMP_23, {$urandom(), $urandom()});
               write_reg(CSR_COMP_45, {$urandom(), $urandom()});
            end
            1: begin  // typical window, small thresholds
               write_reg(CSR_COMP_ENABLE, 64'd1);
               write_reg(CSR_WINDOW_LOW, window_word(int'($urandom_range(5000, 20000))));
               write_reg(CSR_WINDOW_HIGH, window_word(int'($urandom_range(30000, 50000))));
               write_reg(CSR_COMP_01, comp_pair($urandom_range(2000, 4000),
                                                int'($urandom_range(0, 8000)) - 4000,
                                                $urandom_range(1000, 3000),
                                                int'($urandom_range(0, 8000)) - 4000));
               write_reg(CSR_COMP_23, comp_pair($urandom_range(500, 2000),
                                                int'($urandom_range(0, 8000)) - 4000,
                                                $urandom_range(0, 1000),
                                                int'($urandom_range(0, 8000)) - 4000));
               write_reg(CSR_COMP_45, comp_pair($urandom_range(0, 500),
                                                int'($urandom_range(0, 8000)) - 4000,
                                                0, int'($urandom_range(0, 8000)) - 4000));
            end
            2: begin  // reversed extremes; thresholds never reached except the last
               write_reg(CSR_COMP_ENABLE, 64'd1);
               write_reg(CSR_WINDOW_LOW, window_word(TEMP_CEIL));
               write_reg(CSR_WINDOW_HIGH, window_word(TEMP_FLOOR));
               write_reg(CSR_COMP_01, comp_pair(65535, -1, 65535, -1));
               write_reg(CSR_COMP_23, comp_pair(65535, -1, 65535, -1));
               write_reg(CSR_COMP_45, comp_pair(65535, -1, 0, 1500));
            end
            3: begin  // zero-width window, raw random table
               write_reg(CSR_COMP_ENABLE, 64'd1);
               drift_temp = int'($urandom_range(0, 200000)) - 50000;
               write_reg(CSR_WINDOW_LOW, window_word(drift_temp));
               write_reg(CSR_WINDOW_HIGH, window_word(drift_temp));
               write_reg(CSR_COMP_01, {$urandom(), $urandom()});
               write_reg(CSR_COMP_23, {$urandom(), $urandom()});
               write_reg(CSR_COMP_45, {$urandom(), $urandom()});
            end
            4: begin  // raw 19-bit bounds, spare writes again
               write_reg(CSR_COMP_ENABLE, 64'd0);
               write_reg(CSR_WINDOW_LOW, window_word(int'($urandom())));
               write_reg(CSR_WINDOW_HIGH, window_word(int'($urandom())));
               write_reg(CSR_SPARE_6, {$urandom(), $urandom()});
               write_reg(CSR_SPARE_7, {$urandom(), $urandom()});
            end
            default: begin  // random in-range bounds, descending thresholds
               write_reg(CSR_COMP_ENABLE, 64'd1);
               write_reg(CSR_WINDOW_LOW,
                         window_word(int'($urandom_range(0, 200000)) - 50000));
               write_reg(CSR_WINDOW_HIGH,
                         window_word(int'($urandom_range(0, 200000)) - 50000));
               write_reg(CSR_COMP_01, comp_pair(3000, int'($urandom_range(0, 65535)),
                                                2000, int'($urandom_range(0, 65535))));
               write_reg(CSR_COMP_23, comp_pair(1500, int'($urandom_range(0, 65535)),
                                                1000, int'($urandom_range(0, 65535))));
               write_reg(CSR_COMP_45, comp_pair(500, int'($urandom_range(0, 65535)),
                                                100, int'($urandom_range(0, 65535))));
            end
         endcase
         csr_wen <= 1'b0;
         // back-pressure: receiver holds off while the sender keeps offering
         if (phase == 0 || phase == 3) hold_request = 1'b1;
         run_random(100);
      end

      wait_idle();
      repeat (20) @(posedge clock);   // catch stray responses
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
